/* design/tdt_pkg.sv */
`timescale 1ns / 1ps
package tdt_pkg;

  // Event kinds on the input tuser.
  localparam logic [1:0] REQ_DOWN   = 2'd0;
  localparam logic [1:0] REQ_MOVE   = 2'd1;
  localparam logic [1:0] REQ_UP     = 2'd2;
  localparam logic [1:0] REQ_CANCEL = 2'd3;

  // Gesture state codes.
  localparam logic [2:0] GS_UNCHANGED  = 3'd0;
  localparam logic [2:0] GS_POSSIBLE   = 3'd1;
  localparam logic [2:0] GS_FAILED     = 3'd2;
  localparam logic [2:0] GS_RECOGNIZED = 3'd3;
  localparam logic [2:0] GS_CANCELLED  = 3'd4;

  // Arena verdict codes.
  localparam logic [1:0] VD_NONE     = 2'd0;
  localparam logic [1:0] VD_ACCEPTED = 2'd1;
  localparam logic [1:0] VD_REJECTED = 2'd2;

  // Tap kinds.
  localparam logic [1:0] TK_NONE   = 2'd0;
  localparam logic [1:0] TK_SINGLE = 2'd1;
  localparam logic [1:0] TK_DOUBLE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_DIST    = 2'd0;
  localparam logic [1:0] CFG_MAX_DUR     = 2'd1;
  localparam logic [1:0] CFG_DT_ENABLE   = 2'd2;
  localparam logic [1:0] CFG_DT_TIMEOUT  = 2'd3;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIST_BITS     = 12;
  localparam int DUR_BITS      = 16;
  localparam int PID_BITS      = 4;

  localparam logic [DIST_BITS-1:0] RST_MAX_DIST   = 12'd20;
  localparam logic [DUR_BITS-1:0]  RST_MAX_DUR    = 16'd300;
  localparam logic [DUR_BITS-1:0]  RST_DT_TIMEOUT = 16'd300;

  // Field widths of a result beat without the coordinates.
  localparam int GS_BITS = 3;
  localparam int VD_BITS = 2;
  localparam int TK_BITS = 2;

  // Event class worked out by the front part.
  typedef struct packed {
    logic is_down;
    logic is_move;
    logic is_up;
    logic is_cancel;
  } cls_t;

endpackage

/* design/tdt_front.sv */
`timescale 1ns / 1ps
module tdt_front #(
  parameter int DATA_W = 60,
  parameter int IN_TW  = 64
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_TW-1:0]              in_tdata,
  input  logic [1:0]                    in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [DATA_W+$bits(tdt_pkg::cls_t)-1:0] q_wdata
);
  import tdt_pkg::*;

  cls_t cls;

  // Decode the event kind into one flag per class.
  always_comb begin
    cls = '0;
    unique case (in_tuser)
      REQ_DOWN:   cls.is_down   = 1'b1;
      REQ_MOVE:   cls.is_move   = 1'b1;
      REQ_UP:     cls.is_up     = 1'b1;
      REQ_CANCEL: cls.is_cancel = 1'b1;
      default:    cls = '0;
    endcase
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;
  assign q_wdata   = {in_tdata[DATA_W-1:0], cls};

endmodule

/* design/tdt_fifo.sv */
`timescale 1ns / 1ps
module tdt_fifo #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata = mem_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

/* design/tdt_back.sv */
`timescale 1ns / 1ps
module tdt_back #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32,
  parameter int DATA_W     = 60,
  parameter int OUT_TW     = 40
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  input  logic [DATA_W+$bits(tdt_pkg::cls_t)-1:0] q_rdata,
  output logic                                    q_pop,
  input  logic                                    cfg_we,
  input  logic [tdt_pkg::CFG_IDX_BITS-1:0]        cfg_idx,
  input  logic [tdt_pkg::CFG_DATA_BITS-1:0]       cfg_wdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [OUT_TW-1:0]                       out_tdata
);
  import tdt_pkg::*;

  localparam int PROD_W = 2 * COORD_BITS;
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int DSQ_W = 2 * DIST_BITS;
  localparam int CMP_W = (SQ_W > DSQ_W) ? SQ_W : DSQ_W;
  localparam int OUT_W = GS_BITS + VD_BITS + PID_BITS + 1 + TK_BITS + 2 * COORD_BITS;

  function automatic logic [SQ_W-1:0] sq_dist(
    input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
    input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by);
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [PROD_W-1:0]     px;
    logic [PROD_W-1:0]     py;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    px = PROD_W'(dx) * PROD_W'(dx);
    py = PROD_W'(dy) * PROD_W'(dy);
    return {1'b0, px} + {1'b0, py};
  endfunction

  // Head of the queue.
  cls_t                  h_cls;
  logic [PID_BITS-1:0]   h_pid;
  logic [COORD_BITS-1:0] h_x, h_y;
  logic [TIME_BITS-1:0]  h_t;

  assign h_cls = q_rdata[$bits(cls_t)-1:0];
  assign {h_t, h_y, h_x, h_pid} = q_rdata[DATA_W+$bits(cls_t)-1:$bits(cls_t)];

  // Configuration.
  logic [DSQ_W-1:0]    dsq_r, dsq_nxt;
  logic [DUR_BITS-1:0] max_dur_r, max_dur_nxt;
  logic                dt_en_r, dt_en_nxt;
  logic [DUR_BITS-1:0] dt_to_r, dt_to_nxt;

  // Tracking and pairing state.
  logic                  trk_r, trk_nxt;
  logic [PID_BITS-1:0]   tp_r, tp_nxt;
  logic [COORD_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [TIME_BITS-1:0]  dstamp_r, dstamp_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIME_BITS-1:0]  lstamp_r, lstamp_nxt;
  logic [COORD_BITS-1:0] lx_r, lx_nxt, ly_r, ly_nxt;

  logic                  ov_r, ov_nxt;
  logic [OUT_W-1:0]      od_r, od_nxt;

  logic                  fire;
  logic                  mine;
  logic [SQ_W-1:0]       d2_cur, d2_last;
  logic                  near_cur, near_last;
  logic [TIME_BITS-1:0]  dur, gap;
  logic                  dur_ok, gap_ok;
  logic [GS_BITS-1:0]    st;
  logic [VD_BITS-1:0]    vd;
  logic [PID_BITS-1:0]   vp;
  logic                  jn;
  logic [TK_BITS-1:0]    tk;
  logic [COORD_BITS-1:0] tx, ty;

  assign fire  = ~q_empty & (~ov_r | out_tready);
  assign q_pop = fire;
  assign mine  = trk_r & (tp_r == h_pid);

  always_comb begin
    d2_cur    = sq_dist(sx_r, sy_r, h_x, h_y);
    d2_last   = sq_dist(sx_r, sy_r, lx_r, ly_r);
    near_cur  = CMP_W'(d2_cur)  <= CMP_W'(dsq_r);
    near_last = CMP_W'(d2_last) <= CMP_W'(dsq_r);
    dur       = h_t - dstamp_r;
    gap       = h_t - lstamp_r;
    dur_ok    = dur <= TIME_BITS'(max_dur_r);
    gap_ok    = gap <= TIME_BITS'(dt_to_r);
  end

  // The user must write config only while idle; the block itself does not enforce it.
  always_comb begin
    dsq_nxt     = dsq_r;
    max_dur_nxt = max_dur_r;
    dt_en_nxt   = dt_en_r;
    dt_to_nxt   = dt_to_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_DIST:   dsq_nxt = DSQ_W'(cfg_wdata[DIST_BITS-1:0])
                                  * DSQ_W'(cfg_wdata[DIST_BITS-1:0]);
        CFG_MAX_DUR:    max_dur_nxt = cfg_wdata[DUR_BITS-1:0];
        CFG_DT_ENABLE:  dt_en_nxt = cfg_wdata[0];
        CFG_DT_TIMEOUT: dt_to_nxt = cfg_wdata[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Carry out one event.
  always_comb begin
    trk_nxt    = trk_r;
    tp_nxt     = tp_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    dstamp_nxt = dstamp_r;
    pend_nxt   = pend_r;
    lstamp_nxt = lstamp_r;
    lx_nxt     = lx_r;
    ly_nxt     = ly_r;
    st = GS_UNCHANGED;
    vd = VD_NONE;
    vp = '0;
    jn = 1'b0;
    tk = TK_NONE;
    tx = '0;
    ty = '0;
    if (h_cls.is_down) begin
      vp = h_pid;
      if (trk_r) begin
        st = GS_FAILED;
        vd = VD_REJECTED;
      end else begin
        trk_nxt    = 1'b1;
        tp_nxt     = h_pid;
        sx_nxt     = h_x;
        sy_nxt     = h_y;
        dstamp_nxt = h_t;
        st = GS_POSSIBLE;
        jn = 1'b1;
      end
    end else if (h_cls.is_move) begin
      if (mine && !near_cur) begin
        st = GS_FAILED;
        vd = VD_REJECTED;
        vp = h_pid;
        trk_nxt = 1'b0;
      end
    end else if (h_cls.is_up) begin
      if (mine) begin
        vp = h_pid;
        trk_nxt = 1'b0;
        if (dur_ok && near_cur) begin
          st = GS_RECOGNIZED;
          vd = VD_ACCEPTED;
          tx = h_x;
          ty = h_y;
          tk = TK_SINGLE;
          if (dt_en_r) begin
            if (pend_r && gap_ok && near_last) begin
              tk = TK_DOUBLE;
              pend_nxt   = 1'b0;
              lstamp_nxt = '0;
            end else begin
              pend_nxt   = 1'b1;
              lstamp_nxt = h_t;
              lx_nxt     = sx_r;
              ly_nxt     = sy_r;
            end
          end
        end else begin
          st = GS_FAILED;
          vd = VD_REJECTED;
        end
      end
    end else if (h_cls.is_cancel) begin
      if (mine) begin
        st = GS_CANCELLED;
        vd = VD_REJECTED;
        vp = h_pid;
        trk_nxt = 1'b0;
      end
    end
    od_nxt = {ty, tx, tk, jn, vp, vd, st};
    ov_nxt = fire | (ov_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsq_r     <= DSQ_W'(RST_MAX_DIST) * DSQ_W'(RST_MAX_DIST);
      max_dur_r <= RST_MAX_DUR;
      dt_en_r   <= 1'b0;
      dt_to_r   <= RST_DT_TIMEOUT;
      trk_r     <= 1'b0;
      tp_r      <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      dstamp_r  <= '0;
      pend_r    <= 1'b0;
      lstamp_r  <= '0;
      lx_r      <= '0;
      ly_r      <= '0;
      ov_r      <= 1'b0;
    end else begin
      dsq_r     <= dsq_nxt;
      max_dur_r <= max_dur_nxt;
      dt_en_r   <= dt_en_nxt;
      dt_to_r   <= dt_to_nxt;
      ov_r      <= ov_nxt;
      if (fire) begin
        trk_r    <= trk_nxt;
        tp_r     <= tp_nxt;
        sx_r     <= sx_nxt;
        sy_r     <= sy_nxt;
        dstamp_r <= dstamp_nxt;
        pend_r   <= pend_nxt;
        lstamp_r <= lstamp_nxt;
        lx_r     <= lx_nxt;
        ly_r     <= ly_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      od_r <= od_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_TW'(od_r);

endmodule

/* design/tap_double_tap_detector.sv */
`timescale 1ns / 1ps
// Path: the front pushes an accepted beat into a 2-entry queue; the back
// pops it, updates the tracking and pairing state and registers the result
// beat. Throughput: one event per cycle unless the result side stalls.
// Reset: synchronous, active low; clears the queue, the tracking state and
// the output valid, and loads the configuration registers with defaults.
module tap_double_tap_detector #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata fields, lowest bit up: pointer_id, touch_x, touch_y, stamp_ms
  input  logic [((tdt_pkg::PID_BITS + 2 * COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0]
                                               in_tdata,
  // in_tuser fields: req_type
  input  logic [1:0]                           in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata fields, lowest bit up: gesture_state, verdict, verdict_pointer,
  // join_arena, tap_kind, tap_x, tap_y
  output logic [((tdt_pkg::GS_BITS + tdt_pkg::VD_BITS + tdt_pkg::PID_BITS + 1
                  + tdt_pkg::TK_BITS + 2 * COORD_BITS + 7) / 8) * 8 - 1:0]
                                               out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [tdt_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [tdt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import tdt_pkg::*;

  // Payload of an input beat without the kind, and its padded bus width.
  localparam int DATA_W = PID_BITS + 2 * COORD_BITS + TIME_BITS;
  localparam int IN_TW  = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TW = ((GS_BITS + VD_BITS + PID_BITS + 1 + TK_BITS
                            + 2 * COORD_BITS + 7) / 8) * 8;
  // Queue entry: classified kind in the low bits, payload above.
  localparam int Q_W = DATA_W + $bits(cls_t);

  logic           q_full, q_empty, q_push, q_pop;
  logic [Q_W-1:0] q_wdata, q_rdata;

  // Front: classify the beat and push it into the queue.
  tdt_front #(
    .DATA_W (DATA_W),
    .IN_TW  (IN_TW)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // Queue: hold up to two classified events so each side can stall alone.
  tdt_fifo #(
    .W (Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back: advance the gesture state and register the result beat.
  tdt_back #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS),
    .DATA_W     (DATA_W),
    .OUT_TW     (OUT_TW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/tdt_checker.sv */
`timescale 1ns / 1ps
module tdt_checker #(
  parameter int OUT_TW = 40
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);
  import tdt_pkg::*;

  localparam int VD_LO = GS_BITS;
  localparam int JN_AT = GS_BITS + VD_BITS + PID_BITS;
  localparam int TK_LO = JN_AT + 1;

  logic [GS_BITS-1:0] gs;
  logic [VD_BITS-1:0] vd;
  logic               jn;
  logic [TK_BITS-1:0] tk;

  assign gs = out_tdata[GS_BITS-1:0];
  assign vd = out_tdata[VD_LO+VD_BITS-1:VD_LO];
  assign jn = out_tdata[JN_AT];
  assign tk = out_tdata[TK_LO+TK_BITS-1:TK_LO];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_tap_recognized: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tk != TK_NONE |-> gs == GS_RECOGNIZED && vd == VD_ACCEPTED)
    else $error("tap reported without recognized and accepted");

  a_join_possible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && jn |-> gs == GS_POSSIBLE && vd == VD_NONE && tk == TK_NONE)
    else $error("arena join outside a fresh down");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind tap_double_tap_detector tdt_checker #(
  .OUT_TW ($bits(out_tdata))
) u_tdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tdt_pkg::*;

  // One touch event as the generator builds it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] stamp;
    logic [11:0] y;
    logic [11:0] x;
    logic [3:0]  pid;
  } touch_ev_t;

  // Result beat layout, most significant field first so that a cast of
  // out_tdata[35:0] lines up with the port packing.
  typedef struct packed {
    logic [11:0] ty;
    logic [11:0] tx;
    logic [1:0]  tk;
    logic        arena_join;
    logic [3:0]  vp;
    logic [1:0]  vd;
    logic [2:0]  gs;
  } gesture_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [63:0] in_tdata = '0;  // pointer_id, touch_x, touch_y, stamp_ms
  logic [1:0]  in_tuser = '0;  // req_type
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;      // gesture_state, verdict, verdict_pointer,
                               // join_arena, tap_kind, tap_x, tap_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;

  tap_double_tap_detector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  touch_ev_t       touch_q[$];        // events waiting for the driver
  gesture_report_t tap_reports_q[$];  // reports the block still owes us
  int              errors = 0;
  bit              calm = 1'b0;       // no idling on either side while set

  // Mirror of the configuration registers.
  logic [11:0] lim_dist;
  logic [15:0] lim_dur;
  logic        dbl_on;
  logic [15:0] lim_gap;

  // Mirror of the gesture tracking and tap pairing state.
  logic        trk_on;
  logic [3:0]  trk_pid;
  logic [11:0] org_x, org_y;
  logic [31:0] org_stamp;
  logic        single_waiting;
  logic [31:0] prev_tap_stamp;
  logic [11:0] prev_tap_x, prev_tap_y;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Distance test on squared integer distances against the limit.
  function automatic bit near(input logic [11:0] ax, ay, bx, by);
    int unsigned dx, dy, lim;
    dx  = (ax > bx) ? 32'(ax - bx) : 32'(bx - ax);
    dy  = (ay > by) ? 32'(ay - by) : 32'(by - ay);
    lim = 32'(lim_dist);
    return dx * dx + dy * dy <= lim * lim;
  endfunction

  // Advance the gesture state by one event and queue the report it yields.
  task automatic follow_gesture(input touch_ev_t ev);
    gesture_report_t r;
    logic [31:0]     dur, gap;
    bit              mine;
    r    = '0;
    mine = trk_on && trk_pid == ev.pid;
    case (ev.kind)
      REQ_DOWN: begin
        r.vp = ev.pid;
        if (trk_on) begin
          // a second pointer is turned away; the tracked one stays
          r.gs = GS_FAILED;
          r.vd = VD_REJECTED;
        end else begin
          trk_on    = 1'b1;
          trk_pid   = ev.pid;
          org_x     = ev.x;
          org_y     = ev.y;
          org_stamp = ev.stamp;
          r.gs = GS_POSSIBLE;
          r.arena_join = 1'b1;
        end
      end
      REQ_MOVE: begin
        if (mine && !near(org_x, org_y, ev.x, ev.y)) begin
          r.gs = GS_FAILED;
          r.vd = VD_REJECTED;
          r.vp = ev.pid;
          trk_on = 1'b0;
        end
      end
      REQ_UP: begin
        if (mine) begin
          dur  = ev.stamp - org_stamp;  // wraps modulo 2^32
          r.vp = ev.pid;
          if (dur <= {16'd0, lim_dur} && near(org_x, org_y, ev.x, ev.y)) begin
            r.gs = GS_RECOGNIZED;
            r.vd = VD_ACCEPTED;
            r.tx = ev.x;
            r.ty = ev.y;
            if (dbl_on) begin
              gap = ev.stamp - prev_tap_stamp;
              if (single_waiting && gap <= {16'd0, lim_gap} &&
                  near(org_x, org_y, prev_tap_x, prev_tap_y)) begin
                r.tk = TK_DOUBLE;
                single_waiting = 1'b0;
                prev_tap_stamp = '0;
              end else begin
                // remember where the press started, not where it ended
                r.tk = TK_SINGLE;
                single_waiting = 1'b1;
                prev_tap_stamp = ev.stamp;
                prev_tap_x     = org_x;
                prev_tap_y     = org_y;
              end
            end else begin
              r.tk = TK_SINGLE;
            end
          end else begin
            r.gs = GS_FAILED;
            r.vd = VD_REJECTED;
          end
          trk_on = 1'b0;
        end
      end
      default: begin
        if (mine) begin
          r.gs = GS_CANCELLED;
          r.vd = VD_REJECTED;
          r.vp = ev.pid;
          trk_on = 1'b0;
        end
      end
    endcase
    tap_reports_q.push_back(r);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: hold a beat until it is taken, then idle or send the next one.
  int        send_gap = 0;
  touch_ev_t next_ev;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (touch_q.size() != 0) begin
        next_ev   = touch_q.pop_front();
        in_tuser  <= next_ev.kind;
        in_tdata  <= {4'b0, next_ev.stamp, next_ev.y, next_ev.x, next_ev.pid};
        in_tvalid <= 1'b1;
        send_gap  <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall the result side in random bursts.
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_cnt  <= 0;
    end else if (stall_cnt != 0) begin
      stall_cnt  <= stall_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
    end
  end

  // Monitor: mirror register writes, predict on each input beat, check each
  // result beat against the oldest prediction.
  touch_ev_t       seen_ev;
  gesture_report_t want_r, got_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      lim_dist = RST_MAX_DIST;
      lim_dur  = RST_MAX_DUR;
      dbl_on   = 1'b0;
      lim_gap  = RST_DT_TIMEOUT;
      trk_on = 1'b0;  trk_pid = '0;  org_x = '0;  org_y = '0;  org_stamp = '0;
      single_waiting = 1'b0;  prev_tap_stamp = '0;
      prev_tap_x = '0;  prev_tap_y = '0;
      tap_reports_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_DIST:   lim_dist = cfg_wdata[11:0];
          CFG_MAX_DUR:    lim_dur  = cfg_wdata;
          CFG_DT_ENABLE:  dbl_on   = cfg_wdata[0];
          CFG_DT_TIMEOUT: lim_gap  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen_ev = {in_tuser, in_tdata[59:0]};
        follow_gesture(seen_ev);
      end
      if (out_tvalid && out_tready) begin
        got_r = gesture_report_t'(out_tdata[35:0]);
        if (tap_reports_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %h",
                   $time, out_tdata);
          errors++;
        end else begin
          want_r = tap_reports_q.pop_front();
          check_field("gesture_state",   32'(want_r.gs),         32'(got_r.gs));
          check_field("verdict",         32'(want_r.vd),         32'(got_r.vd));
          check_field("verdict_pointer", 32'(want_r.vp),         32'(got_r.vp));
          check_field("join_arena",      32'(want_r.arena_join), 32'(got_r.arena_join));
          check_field("tap_kind",        32'(want_r.tk),         32'(got_r.tk));
          check_field("tap_x",           32'(want_r.tx),         32'(got_r.tx));
          check_field("tap_y",           32'(want_r.ty),         32'(got_r.ty));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  logic [31:0] now_ms;

  task automatic push_ev(input logic [1:0] kind, input logic [3:0] pid,
                         input logic [11:0] x, y, input logic [31:0] stamp);
    touch_ev_t ev;
    ev.kind  = kind;
    ev.pid   = pid;
    ev.x     = x;
    ev.y     = y;
    ev.stamp = stamp;
    touch_q.push_back(ev);
  endtask

  function automatic logic [11:0] clip12(input int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'hFFF;
    return v[11:0];
  endfunction

  function automatic int jitter(input int w);
    return int'($urandom_range(0, 2 * w)) - w;
  endfunction

  // One press: down, up to three moves, then up or cancel after span_ms.
  // Moves and the release wander up to wob pixels from the start point;
  // now and then a foreign pointer pokes in.
  task automatic add_press(input logic [3:0] pid, input int x0, y0,
                           input logic [31:0] span_ms, input int wob,
                           input bit cancel_it, inout int count);
    logic [11:0] sx, sy;
    logic [31:0] t0;
    logic [3:0]  fpid;
    int          nm;
    sx = clip12(x0);
    sy = clip12(y0);
    t0 = now_ms;
    push_ev(REQ_DOWN, pid, sx, sy, t0);
    nm = $urandom_range(0, 3);
    repeat (nm) begin
      push_ev(REQ_MOVE, pid, clip12(sx + jitter(wob)), clip12(sy + jitter(wob)),
              t0 + $urandom_range(0, 50));
      count++;
    end
    if ($urandom_range(0, 9) == 0) begin
      fpid = pid ^ 4'($urandom_range(1, 15));
      push_ev($urandom_range(0, 1) ? REQ_DOWN : REQ_MOVE, fpid,
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), t0);
      count++;
    end
    now_ms = t0 + span_ms;
    push_ev(cancel_it ? REQ_CANCEL : REQ_UP, pid, clip12(sx + jitter(wob)),
            clip12(sy + jitter(wob)), now_ms);
    count += 2;
  endtask

  function automatic logic [31:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 32'(lim_dur));
    if (r < 97) return 32'(lim_dur) + $urandom_range(1, 1000);
    return $urandom;  // includes stamps that run backwards
  endfunction

  function automatic int pick_wob();
    if ($urandom_range(0, 99) < 75) return int'(lim_dist) / 2;
    return int'(lim_dist) + int'($urandom_range(1, 50));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] d, u, e, g);
    write_reg(CFG_MAX_DIST, d);
    write_reg(CFG_MAX_DUR, u);
    write_reg(CFG_DT_ENABLE, e);
    write_reg(CFG_DT_TIMEOUT, g);
  endtask

  // Hold off until every beat is sent and every report has come back,
  // then let the pipeline settle.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((touch_q.size() != 0 || in_tvalid || tap_reports_q.size() != 0) &&
           guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int          count, r, ph;
    int          x, y, wob;
    logic [3:0]  p;
    logic [15:0] d, u, e, g;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: distance 20, duration 300, no pairing.
    push_ev(REQ_UP,     4'd1, 12'd10, 12'd10, 32'd0);       // nothing tracked
    push_ev(REQ_MOVE,   4'd1, 12'd10, 12'd10, 32'd0);
    push_ev(REQ_CANCEL, 4'd1, 12'd10, 12'd10, 32'd0);
    push_ev(REQ_DOWN,   4'd15, 12'hFFF, 12'hFFF, 32'hFFFF_FFF0);
    push_ev(REQ_DOWN,   4'd3, 12'd0, 12'd0, 32'd5);         // second pointer
    push_ev(REQ_MOVE,   4'd3, 12'd0, 12'd0, 32'd6);         // not tracked
    push_ev(REQ_MOVE,   4'd15, 12'd4083, 12'd4079, 32'd7);  // right on the limit
    push_ev(REQ_UP,     4'd15, 12'hFFF, 12'hFFF, 32'h10);   // time wraps
    push_ev(REQ_DOWN,   4'd0, 12'd0, 12'd0, 32'd100);
    push_ev(REQ_MOVE,   4'd0, 12'd21, 12'd0, 32'd110);      // moved too far
    push_ev(REQ_UP,     4'd0, 12'd0, 12'd0, 32'd120);
    push_ev(REQ_DOWN,   4'd5, 12'd2048, 12'd1024, 32'd200);
    push_ev(REQ_CANCEL, 4'd5, 12'd2048, 12'd1024, 32'd210);
    push_ev(REQ_DOWN,   4'd6, 12'd50, 12'd50, 32'd1000);
    push_ev(REQ_UP,     4'd6, 12'd50, 12'd50, 32'd999);     // stamp before down
    push_ev(REQ_DOWN,   4'd7, 12'd100, 12'd100, 32'd2000);
    push_ev(REQ_UP,     4'd7, 12'd120, 12'd100, 32'd2300);  // both limits exact
    push_ev(REQ_DOWN,   4'd8, 12'd100, 12'd100, 32'd3000);
    push_ev(REQ_UP,     4'd8, 12'd121, 12'd100, 32'd3010);  // one pixel too far
    push_ev(REQ_DOWN,   4'd9, 12'd100, 12'd100, 32'd4000);
    push_ev(REQ_UP,     4'd9, 12'd100, 12'd100, 32'd4301);  // one ms too long
    wait_idle();

    // Directed pairing: single, double, single again, then a far tap.
    write_reg(CFG_DT_ENABLE, 16'd1);
    push_ev(REQ_DOWN, 4'd2, 12'd500, 12'd500, 32'd10000);
    push_ev(REQ_UP,   4'd2, 12'd500, 12'd500, 32'd10050);
    push_ev(REQ_DOWN, 4'd2, 12'd510, 12'd500, 32'd10100);
    push_ev(REQ_UP,   4'd2, 12'd510, 12'd500, 32'd10150);
    push_ev(REQ_DOWN, 4'd4, 12'd500, 12'd500, 32'd10200);
    push_ev(REQ_UP,   4'd4, 12'd500, 12'd500, 32'd10250);
    push_ev(REQ_DOWN, 4'd4, 12'd900, 12'd900, 32'd10300);
    push_ev(REQ_UP,   4'd4, 12'd900, 12'd900, 32'd10350);
    wait_idle();

    // Random phases, each under its own setting; the sender drains fully
    // before every register change.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin d = 16'd20; u = 16'd300; e = 16'd1; g = 16'd300; end
        1: begin d = 16'd0;  u = 16'd0;   e = 16'd1; g = 16'd0;   end
        2: begin d = 16'hFFFF; u = 16'hFFFF; e = 16'hFFFF; g = 16'hFFFF; end
        default: begin
          // upper bits beyond each register's width get random junk
          d = {4'($urandom), 12'($urandom_range(1, 200))};
          u = 16'($urandom_range(20, 1000));
          e = {15'($urandom), 1'($urandom_range(0, 99) < 70)};
          g = 16'($urandom_range(20, 1000));
        end
      endcase
      apply_setting(d, u, e, g);
      calm   = (ph == 3 || ph == 7);
      now_ms = (ph == 5) ? 32'hFFFF_FF00 : $urandom;
      count  = 0;
      while (count < 130) begin
        r = $urandom_range(0, 99);
        now_ms += $urandom_range(0, 2000);
        p = 4'($urandom_range(0, 15));
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        if (r < 60) begin
          add_press(p, x, y, pick_span(), pick_wob(), $urandom_range(0, 99) < 8, count);
        end else if (r < 88) begin
          // two presses near the same spot, the second mostly starting inside the timeout
          wob = int'(lim_dist) / 2;
          add_press(p, x, y, pick_span(), pick_wob(), 1'b0, count);
          now_ms += ($urandom_range(0, 99) < 80)
                    ? $urandom_range(0, 32'(lim_gap) / 2)
                    : 32'(lim_gap) + $urandom_range(0, 500);
          add_press($urandom_range(0, 1) ? p : 4'($urandom), x + jitter(wob),
                    y + jitter(wob), $urandom_range(0, 32'(lim_dur) / 2), wob, 1'b0,
                    count);
        end else begin
          // noise: fully random events, not counted
          repeat ($urandom_range(1, 3))
            push_ev(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                    12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    $urandom);
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (tap_reports_q.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, tap_reports_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/tdt_pkg.sv
design/tdt_front.sv
design/tdt_fifo.sv
design/tdt_back.sv
design/tap_double_tap_detector.sv
design/tdt_checker.sv
tb/tb.sv
